[rtl/core/rhc_pkg.sv]
package rhc_pkg;

    // Field widths
    localparam int CH_W  = 8;   // one color channel
    localparam int HUE_W = 16;  // hue, fraction of a full turn
    // Hue divisor is 6*delta, which needs three bits more than a channel
    localparam int DEN_W = CH_W + 3;

    // Divider pipeline: restoring steps per stage and stage count
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STEPS  = (HUE_W > CH_W) ? HUE_W : CH_W;
    localparam int DIV_STAGES = (DIV_STEPS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

    // Which channel holds the maximum
    localparam logic [1:0] SEL_RED   = 2'd0;
    localparam logic [1:0] SEL_GREEN = 2'd1;
    localparam logic [1:0] SEL_BLUE  = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rhc_rgb;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  saturation;
        logic [CH_W-1:0]  brightness;
    } t_rhc_hsv;

    // Operands handed from the front end to the divider
    typedef struct packed {
        logic [DEN_W-1:0] hue_num;  // always below hue_den
        logic [DEN_W-1:0] hue_den;
        logic [CH_W-1:0]  sat_rem;  // upper half of delta*(2^CH_W-1), below sat_den
        logic [CH_W-1:0]  sat_low;  // lower half, shifted in one bit per step
        logic [CH_W-1:0]  sat_den;
        logic [CH_W-1:0]  bright;
    } t_rhc_div;

    // Per-stage state of the divider
    typedef struct packed {
        logic [DEN_W-1:0] hue_rem;
        logic [DEN_W-1:0] hue_den;
        logic [HUE_W-1:0] hue_q;
        logic [CH_W-1:0]  sat_rem;
        logic [CH_W-1:0]  sat_low;
        logic [CH_W-1:0]  sat_den;
        logic [CH_W-1:0]  sat_q;
        logic [CH_W-1:0]  bright;
    } t_rhc_work;

endpackage

[rtl/core/rhc_front.sv]
module rhc_front
    import rhc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_rhc_rgb i_pixel,
    output logic     o_valid,
    input  logic     i_stall,
    output t_rhc_div o_work
);

    // Stage A: max, min and the hue difference term
    logic                   r_va;
    logic [CH_W-1:0]        r_mx;
    logic [CH_W-1:0]        r_mn;
    logic [1:0]             r_sel;
    logic signed [CH_W:0]   r_diff;

    logic [CH_W-1:0]        n_mx;
    logic [CH_W-1:0]        n_mn;
    logic [1:0]             n_sel;
    logic signed [CH_W:0]   n_diff;

    // Stage B: divider operands
    logic                   r_vb;
    t_rhc_div               r_work;
    t_rhc_div               n_work;

    logic                   en_a;
    logic                   en_b;

    logic [CH_W-1:0]        delta;
    logic                   gray;
    logic [DEN_W-1:0]       six;
    logic [DEN_W-1:0]       offset;
    logic signed [DEN_W:0]  term;
    logic signed [DEN_W:0]  term_w;
    logic [2*CH_W-1:0]      sat_num;

    assign en_b    = !r_vb || !i_stall;
    assign en_a    = !r_va || en_b;
    assign o_stall = !en_a;

    always_comb begin
        if (i_pixel.red >= i_pixel.green && i_pixel.red >= i_pixel.blue) begin
            n_sel  = SEL_RED;
            n_mx   = i_pixel.red;
            n_mn   = (i_pixel.green < i_pixel.blue) ? i_pixel.green : i_pixel.blue;
            n_diff = $signed({1'b0, i_pixel.green}) - $signed({1'b0, i_pixel.blue});
        end else if (i_pixel.green >= i_pixel.blue) begin
            n_sel  = SEL_GREEN;
            n_mx   = i_pixel.green;
            n_mn   = (i_pixel.red < i_pixel.blue) ? i_pixel.red : i_pixel.blue;
            n_diff = $signed({1'b0, i_pixel.blue}) - $signed({1'b0, i_pixel.red});
        end else begin
            n_sel  = SEL_BLUE;
            n_mx   = i_pixel.blue;
            n_mn   = (i_pixel.red < i_pixel.green) ? i_pixel.red : i_pixel.green;
            n_diff = $signed({1'b0, i_pixel.red}) - $signed({1'b0, i_pixel.green});
        end
    end

    always_comb begin
        delta = r_mx - r_mn;
        gray  = (delta == '0);
        six   = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
        case (r_sel)
            SEL_GREEN: offset = {2'b00, delta, 1'b0};
            SEL_BLUE:  offset = {1'b0, delta, 2'b00};
            default:   offset = '0;
        endcase
        term = $signed({1'b0, offset})
             + $signed({{(DEN_W - CH_W){r_diff[CH_W]}}, r_diff});
        // Wrap a negative term (red maximum, green below blue) into one turn
        term_w = term[DEN_W] ? (term + $signed({1'b0, six})) : term;
        // delta * (2^CH_W - 1)
        sat_num = {delta, {CH_W{1'b0}}} - {{CH_W{1'b0}}, delta};

        // A gray pixel divides zero by one on both paths
        n_work.hue_num = gray ? '0 : term_w[DEN_W-1:0];
        n_work.hue_den = gray ? DEN_W'(1) : six;
        n_work.sat_rem = sat_num[2*CH_W-1:CH_W];
        n_work.sat_low = sat_num[CH_W-1:0];
        n_work.sat_den = gray ? CH_W'(1) : r_mx;
        n_work.bright  = r_mx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_valid) begin
            r_mx   <= n_mx;
            r_mn   <= n_mn;
            r_sel  <= n_sel;
            r_diff <= n_diff;
        end
        if (en_b && r_va) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_vb;
    assign o_work  = r_work;

endmodule

[rtl/core/rhc_divider.sv]
module rhc_divider
    import rhc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_rhc_div i_work,
    output logic     o_valid,
    input  logic     i_stall,
    output t_rhc_hsv o_pixel
);

    localparam int LAST = DIV_STAGES - 1;

    logic      r_v   [DIV_STAGES];
    t_rhc_work r_st  [DIV_STAGES];
    logic      v_in  [DIV_STAGES];
    t_rhc_work w_in  [DIV_STAGES];
    t_rhc_work n_st  [DIV_STAGES];
    logic      en    [DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++) begin : g_stage
            if (s == 0) begin : g_head
                assign v_in[s]         = i_valid;
                assign w_in[s].hue_rem = i_work.hue_num;
                assign w_in[s].hue_den = i_work.hue_den;
                assign w_in[s].hue_q   = '0;
                assign w_in[s].sat_rem = i_work.sat_rem;
                assign w_in[s].sat_low = i_work.sat_low;
                assign w_in[s].sat_den = i_work.sat_den;
                assign w_in[s].sat_q   = '0;
                assign w_in[s].bright  = i_work.bright;
            end else begin : g_body
                assign v_in[s] = r_v[s-1];
                assign w_in[s] = r_st[s-1];
            end

            if (s == LAST) begin : g_tail
                assign en[s] = !r_v[s] || !i_stall;
            end else begin : g_mid
                assign en[s] = !r_v[s] || en[s+1];
            end

            // Restoring division: DIV_STEPS_PER_STAGE hue quotient bits per stage, saturation bits in the early stages
            always_comb begin
                t_rhc_work      w;
                logic [DEN_W:0] hue_sh;
                logic [CH_W:0]  sat_sh;
                w = w_in[s];
                for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
                    if (s * DIV_STEPS_PER_STAGE + j < HUE_W) begin
                        hue_sh = {w.hue_rem, 1'b0};
                        if (hue_sh >= {1'b0, w.hue_den}) begin
                            hue_sh    = hue_sh - {1'b0, w.hue_den};
                            w.hue_q   = {w.hue_q[HUE_W-2:0], 1'b1};
                        end else begin
                            w.hue_q   = {w.hue_q[HUE_W-2:0], 1'b0};
                        end
                        w.hue_rem = hue_sh[DEN_W-1:0];
                    end
                    if (s * DIV_STEPS_PER_STAGE + j < CH_W) begin
                        sat_sh    = {w.sat_rem, w.sat_low[CH_W-1]};
                        w.sat_low = {w.sat_low[CH_W-2:0], 1'b0};
                        if (sat_sh >= {1'b0, w.sat_den}) begin
                            sat_sh  = sat_sh - {1'b0, w.sat_den};
                            w.sat_q = {w.sat_q[CH_W-2:0], 1'b1};
                        end else begin
                            w.sat_q = {w.sat_q[CH_W-2:0], 1'b0};
                        end
                        w.sat_rem = sat_sh[CH_W-1:0];
                    end
                end
                n_st[s] = w;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (en[s]) begin
                    r_v[s] <= v_in[s];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en[s] && v_in[s]) begin
                    r_st[s] <= n_st[s];
                end
            end
        end
    endgenerate

    assign o_stall            = !en[0];
    assign o_valid            = r_v[LAST];
    assign o_pixel.hue        = r_st[LAST].hue_q;
    assign o_pixel.saturation = r_st[LAST].sat_q;
    assign o_pixel.brightness = r_st[LAST].bright;

    // Partial remainders must stay below their divisors; checked in the first stage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> (r_st[0].hue_rem < r_st[0].hue_den) && (r_st[0].sat_rem < r_st[0].sat_den))
        else $error("divider remainder out of range in first stage");

    // Zero saturation only for a gray pixel, whose hue is zero too
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_pixel.saturation == '0) |-> (o_pixel.hue == '0))
        else $error("nonzero hue with zero saturation");

    // Reset empties the pipe
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

[rtl/core/rgb_to_hsv_convert_top.sv]
// RGB to HSV pixel converter, 8-bit channels in, 16-bit hue fraction out.
// Pipeline: 2 + DIV_STAGES register stages, 10 at the default widths.
// Throughput: one transaction per cycle while not stalled; two restoring-divider steps per stage.
// Reset: synchronous, active low; clears every stage valid bit, the pipe drains
// empty and no result is presented until new transactions enter.
module rgb_to_hsv_convert_top
    import rhc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    // Pixel input channel
    input  logic     i_valid,
    output logic     o_stall,
    input  t_rhc_rgb i_pixel,
    // HSV result channel
    output logic     o_valid,
    input  logic     i_stall,
    output t_rhc_hsv o_pixel
);

    // Front end: two stages.
    //   A: pick the maximum channel (red wins ties, then green), the minimum,
    //      and the signed channel difference for the hue sector.
    //   B: delta, divisor 6*delta, sector offset plus wrap, and the saturation
    //      numerator delta*255. Gray pixels turn into 0/1 divisions.
    // Divider: DIV_STAGES stages, each resolving two hue quotient bits and,
    // in the early stages, two saturation quotient bits. Stall backs up stage
    // by stage, so empty stages still fill while the output is held.

    logic     front_valid;
    logic     div_stall;
    t_rhc_div front_work;

    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pixel (i_pixel),
        .o_valid (front_valid),
        .i_stall (div_stall),
        .o_work  (front_work)
    );

    rhc_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_stall (div_stall),
        .i_work  (front_work),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pixel (o_pixel)
    );

endmodule

[dv/tb.sv]
module tb;
    import rhc_pkg::*;

    // Pipeline depth at the default widths, plus margin for the drain
    localparam int unsigned PIPE_DEPTH   = 2 + DIV_STAGES;
    localparam int unsigned DRAIN_CYCLES = PIPE_DEPTH + 8;
    localparam int unsigned NUM_RANDOM   = 1950;
    localparam int unsigned HOLD_CYCLES  = 400;
    // Allow for the stalled pixels plus the long hold-offs;
    // take that several times over.
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned CLK_HALF     = 6;

    // Keep the expected HSV values in arrival order and compare each
    // accepted result against the oldest one.
    class hsv_scoreboard;
        t_rhc_hsv    pending_hsv[$];
        int unsigned pixels_in;
        int unsigned results_out;
        int unsigned errors;

        // Compute the exact HSV triple for one pixel with integer math.
        function t_rhc_hsv rgb_to_hsv(t_rhc_rgb px);
            int                r;
            int                g;
            int                b;
            int                top;
            int                bottom;
            int                delta;
            int                six;
            int                term;
            longint unsigned   frac;
            t_rhc_hsv          res;
            r      = px.red;
            g      = px.green;
            b      = px.blue;
            top    = (r > g) ? r : g;
            top    = (b > top) ? b : top;
            bottom = (r < g) ? r : g;
            bottom = (b < bottom) ? b : bottom;
            delta  = top - bottom;
            res.hue        = '0;
            res.saturation = '0;
            res.brightness = CH_W'(top);
            if (delta > 0) begin
                six = 6 * delta;
                res.saturation = CH_W'((delta * ((1 << CH_W) - 1)) / top);
                // Red wins a tie with green, green wins a tie with blue
                if (top == r) begin
                    term = g - b;
                end else if (top == g) begin
                    term = 2 * delta + b - r;
                end else begin
                    term = 4 * delta + r - g;
                end
                // Wrap a negative term by one full turn
                if (term < 0) begin
                    term += six;
                end
                frac = term % six;
                frac = frac << HUE_W;
                res.hue = HUE_W'(frac / six);
            end
            return res;
        endfunction

        function void note_pixel(t_rhc_rgb px);
            pixels_in++;
            pending_hsv.push_back(rgb_to_hsv(px));
        endfunction

        function void check_pixel(t_rhc_hsv got);
            t_rhc_hsv want;
            results_out++;
            if (pending_hsv.size() == 0) begin
                $error("unexpected result: hue %0d saturation %0d brightness %0d",
                       got.hue, got.saturation, got.brightness);
                errors++;
                return;
            end
            want = pending_hsv.pop_front();
            if (got.hue !== want.hue) begin
                $error("hue: expected %0d, actual %0d", want.hue, got.hue);
                errors++;
            end
            if (got.saturation !== want.saturation) begin
                $error("saturation: expected %0d, actual %0d",
                       want.saturation, got.saturation);
                errors++;
            end
            if (got.brightness !== want.brightness) begin
                $error("brightness: expected %0d, actual %0d",
                       want.brightness, got.brightness);
                errors++;
            end
        endfunction
    endclass

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_stall = 1'b0;
    t_rhc_rgb i_pixel = '0;
    logic     o_stall;
    logic     o_valid;
    t_rhc_hsv o_pixel;

    hsv_scoreboard sb = new();

    int unsigned input_held_cycles  = 0;
    int unsigned output_stall_cycles = 0;

    rgb_to_hsv_convert_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_pixel (o_pixel)
    );

    // Clock: 12 time units per period
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Sample both channels at the rising edge. Note the input transaction
    // first so the expectation is queued before any result is checked.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_valid === 1'b1 && o_stall === 1'b0) begin
                sb.note_pixel(i_pixel);
            end
            if (i_valid === 1'b1 && o_stall !== 1'b0) begin
                input_held_cycles++;
            end
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                sb.check_pixel(o_pixel);
            end
            if (o_valid === 1'b1 && i_stall === 1'b1) begin
                output_stall_cycles++;
            end
        end
    end

    // Present one pixel from a falling edge and hold it until the block
    // takes it; return at the falling edge after the transaction.
    task automatic send_pixel(input t_rhc_rgb px);
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        @(negedge i_clk);
    endtask

    // Drop valid for a gap between bursts.
    task automatic pause_sender(input int unsigned cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Draw a pixel: mostly uniform, with a share of gray pixels, tied
    // maxima, near-gray pixels and channel extremes.
    function automatic t_rhc_rgb random_pixel();
        t_rhc_rgb    px;
        int unsigned hi;
        int unsigned lo;
        int unsigned pick;
        px = t_rhc_rgb'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                hi = $urandom_range(0, 255);
                px = '{red: CH_W'(hi), green: CH_W'(hi), blue: CH_W'(hi)};
            end
            1: begin
                hi   = $urandom_range(1, 255);
                lo   = $urandom_range(0, hi - 1);
                pick = $urandom_range(0, 2);
                case (pick)
                    0: px = '{red: CH_W'(hi), green: CH_W'(hi), blue: CH_W'(lo)};
                    1: px = '{red: CH_W'(hi), green: CH_W'(lo), blue: CH_W'(hi)};
                    default: px = '{red: CH_W'(lo), green: CH_W'(hi), blue: CH_W'(hi)};
                endcase
            end
            2: begin
                hi = $urandom_range(0, 252);
                px.red   = CH_W'(hi + $urandom_range(0, 3));
                px.green = CH_W'(hi + $urandom_range(0, 3));
                px.blue  = CH_W'(hi + $urandom_range(0, 3));
            end
            3: begin
                px.red   = CH_W'($urandom_range(0, 1) ? 255 - $urandom_range(0, 1)
                                                      : $urandom_range(0, 1));
                px.green = CH_W'($urandom_range(0, 1) ? 255 - $urandom_range(0, 1)
                                                      : $urandom_range(0, 1));
                px.blue  = CH_W'($urandom_range(0, 1) ? 255 - $urandom_range(0, 1)
                                                      : $urandom_range(0, 1));
            end
            default: ;
        endcase
        return px;
    endfunction

    // Corner pixels: black, white, gray, primaries, every tied maximum,
    // the red-maximum wrap, unit deltas and alternating bit patterns.
    t_rhc_rgb corner_pixels[] = '{
        '{red: 8'd0,   green: 8'd0,   blue: 8'd0},
        '{red: 8'd255, green: 8'd255, blue: 8'd255},
        '{red: 8'd128, green: 8'd128, blue: 8'd128},
        '{red: 8'd255, green: 8'd0,   blue: 8'd0},
        '{red: 8'd0,   green: 8'd255, blue: 8'd0},
        '{red: 8'd0,   green: 8'd0,   blue: 8'd255},
        '{red: 8'd255, green: 8'd255, blue: 8'd0},
        '{red: 8'd255, green: 8'd0,   blue: 8'd255},
        '{red: 8'd0,   green: 8'd255, blue: 8'd255},
        '{red: 8'd255, green: 8'd0,   blue: 8'd1},
        '{red: 8'd255, green: 8'd10,  blue: 8'd200},
        '{red: 8'd10,  green: 8'd255, blue: 8'd3},
        '{red: 8'd3,   green: 8'd10,  blue: 8'd255},
        '{red: 8'd1,   green: 8'd0,   blue: 8'd0},
        '{red: 8'd0,   green: 8'd1,   blue: 8'd0},
        '{red: 8'd0,   green: 8'd0,   blue: 8'd1},
        '{red: 8'd1,   green: 8'd1,   blue: 8'd0},
        '{red: 8'd255, green: 8'd254, blue: 8'd254},
        '{red: 8'd254, green: 8'd255, blue: 8'd254},
        '{red: 8'd200, green: 8'd100, blue: 8'd50},
        '{red: 8'd170, green: 8'd85,  blue: 8'd170},
        '{red: 8'd85,  green: 8'd170, blue: 8'd85}
    };

    // Main sequence: reset, corner pixels, random bursts, drain, verdict.
    initial begin
        int unsigned left;
        int unsigned burst;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Push corner pixels back to back
        foreach (corner_pixels[k]) begin
            send_pixel(corner_pixels[k]);
        end
        pause_sender(3);

        // Send random pixels in bursts with random gaps between them
        left = NUM_RANDOM;
        while (left > 0) begin
            burst = $urandom_range(1, 48);
            while (burst > 0 && left > 0) begin
                send_pixel(random_pixel());
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0) begin
                pause_sender($urandom_range(1, 8));
            end
        end
        pause_sender(1);

        // Wait for every expected result, then let the pipe settle
        while (sb.pending_hsv.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("converted %0d pixels into %0d HSV results, %0d mismatches",
                 sb.pixels_in, sb.results_out, sb.errors);
        $display("input held back on %0d cycles, output stalled on %0d cycles",
                 input_held_cycles, output_stall_cycles);
        if (sb.errors == 0 && sb.pending_hsv.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Receiver: stall on a pattern of its own in segments of random mode and
    // length. Twice during the random part, hold off for a long stretch so
    // the pipe fills up and the block pushes back on its input.
    initial begin
        int unsigned holds;
        int unsigned mode;
        int unsigned seg;
        holds = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (holds < 2 && sb.pixels_in >= 150 + 900 * holds) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds++;
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(8, 120);
            for (int n = 0; n < seg; n++) begin
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ((n % 5) >= 3);
                endcase
                @(negedge i_clk);
            end
        end
    end

    // Watchdog: end the run if it hangs
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("TB_ERROR");
        $finish;
    end

endmodule
